// ===== rtl/core/m3i_pkg.sv =====
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared constants and types for the 3x3 fixed-point matrix inverse.
// ----------------------------------------------------------------------------
package m3i_pkg;

	localparam int IN_W     = 16;
	localparam int OUT_W    = 32;
	localparam int N_EL     = 9;
	localparam int PROD_W   = 32;
	localparam int COF_W    = 33;
	localparam int MAG_W    = 32;
	localparam int DETP_W   = 49;
	localparam int DETS_W   = 50;
	localparam int DET_W    = 48;
	localparam int IN_FRAC  = 8;
	localparam int OUT_FRAC = 16;
	localparam int SCALE    = IN_FRAC + OUT_FRAC;
	localparam int Q_W      = 32;
	localparam int HI_SH    = Q_W - SCALE;
	localparam int CMP_W    = DET_W + HI_SH;
	localparam int DIV_ST   = Q_W;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = 2;
	localparam int QCNT_W   = 3;

	localparam logic [N_EL-1:0]  NEG_MASK = 9'b010101010;
	localparam logic [OUT_W-1:0] OUT_MAX  = 32'h7FFF_FFFF;
	localparam logic [OUT_W-1:0] OUT_MIN  = 32'h8000_0000;

	typedef struct packed {
		logic [N_EL-1:0][MAG_W-1:0] n;
		logic [N_EL-1:0]            neg;
		logic [N_EL-1:0]            ovf;
		logic [DET_W-1:0]           d;
		logic                       sing;
	} item_t;

endpackage

// ===== rtl/core/m3i_if.sv =====
// ----------------------------------------------------------------------------
// m3i_if
// Handshake channels for matrix words in and inverse words out.
// ----------------------------------------------------------------------------
interface m3i_in_if;
	logic valid;
	logic ready;
	logic signed [m3i_pkg::IN_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

	modport source(output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
		input ready);
	modport sink(input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
		output ready);
	modport monitor(input valid, ready, a00, a01, a02, a10, a11, a12, a20, a21, a22);
endinterface

interface m3i_out_if;
	logic valid;
	logic ready;
	logic signed [m3i_pkg::OUT_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic singular;
	logic saturated;

	modport source(output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		singular, saturated, input ready);
	modport sink(input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		singular, saturated, output ready);
	modport monitor(input valid, ready, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		singular, saturated);
endinterface

// ===== rtl/core/m3i_front.sv =====
// ----------------------------------------------------------------------------
// m3i_front
// Five-stage front end: minors, signed cofactors, determinant, and the
// magnitude, sign and overflow classification of each quotient.
// ----------------------------------------------------------------------------
module m3i_front (
	input  logic              clk,
	input  logic              arst_n,
	m3i_in_if.sink            mat,
	output m3i_pkg::item_t    item,
	output logic              item_valid,
	input  logic              item_space
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [m3i_pkg::PROD_W-1:0] pa_s1 [m3i_pkg::N_EL];
	logic signed [m3i_pkg::PROD_W-1:0] pb_s1 [m3i_pkg::N_EL];
	logic signed [m3i_pkg::IN_W-1:0]   r0_s1 [3];
	logic signed [m3i_pkg::IN_W-1:0]   r0_s2 [3];
	logic signed [m3i_pkg::COF_W-1:0]  c_s2  [m3i_pkg::N_EL];
	logic signed [m3i_pkg::DETP_W-1:0] p_s3  [3];
	logic [m3i_pkg::N_EL-1:0][m3i_pkg::MAG_W-1:0] n_s3, n_s4;
	logic [m3i_pkg::N_EL-1:0] cneg_s3, cneg_s4;
	logic signed [m3i_pkg::DETS_W-1:0] det_s4;
	m3i_pkg::item_t item_s5;

	logic signed [m3i_pkg::COF_W-1:0] m_c [m3i_pkg::N_EL];
	logic signed [m3i_pkg::DETS_W-1:0] det_neg;
	logic [m3i_pkg::DET_W-1:0] dabs;

	assign en         = !v_s5 || item_space;
	assign mat.ready  = en;
	assign item_valid = v_s5;
	assign item       = item_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= mat.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		for (int k = 0; k < m3i_pkg::N_EL; k++) begin
			m_c[k] = m3i_pkg::COF_W'(pa_s1[k]) - m3i_pkg::COF_W'(pb_s1[k]);
		end
		det_neg = -det_s4;
		dabs = det_s4[m3i_pkg::DETS_W-1] ? det_neg[m3i_pkg::DET_W-1:0]
			: det_s4[m3i_pkg::DET_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1[0] <= mat.a11 * mat.a22;  pb_s1[0] <= mat.a12 * mat.a21;
			pa_s1[1] <= mat.a01 * mat.a22;  pb_s1[1] <= mat.a02 * mat.a21;
			pa_s1[2] <= mat.a01 * mat.a12;  pb_s1[2] <= mat.a02 * mat.a11;
			pa_s1[3] <= mat.a10 * mat.a22;  pb_s1[3] <= mat.a12 * mat.a20;
			pa_s1[4] <= mat.a00 * mat.a22;  pb_s1[4] <= mat.a02 * mat.a20;
			pa_s1[5] <= mat.a00 * mat.a12;  pb_s1[5] <= mat.a02 * mat.a10;
			pa_s1[6] <= mat.a10 * mat.a21;  pb_s1[6] <= mat.a11 * mat.a20;
			pa_s1[7] <= mat.a00 * mat.a21;  pb_s1[7] <= mat.a01 * mat.a20;
			pa_s1[8] <= mat.a00 * mat.a11;  pb_s1[8] <= mat.a01 * mat.a10;
			r0_s1[0] <= mat.a00;
			r0_s1[1] <= mat.a01;
			r0_s1[2] <= mat.a02;

			for (int k = 0; k < m3i_pkg::N_EL; k++) begin
				c_s2[k] <= m3i_pkg::NEG_MASK[k] ? -m_c[k] : m_c[k];
			end
			r0_s2 <= r0_s1;

			for (int j = 0; j < 3; j++) begin
				p_s3[j] <= r0_s2[j] * c_s2[3*j];
			end
			for (int k = 0; k < m3i_pkg::N_EL; k++) begin
				n_s3[k]    <= c_s2[k][m3i_pkg::COF_W-1] ? m3i_pkg::MAG_W'(-c_s2[k])
					: m3i_pkg::MAG_W'(c_s2[k]);
				cneg_s3[k] <= c_s2[k][m3i_pkg::COF_W-1];
			end

			det_s4  <= m3i_pkg::DETS_W'(p_s3[0]) + m3i_pkg::DETS_W'(p_s3[1])
				+ m3i_pkg::DETS_W'(p_s3[2]);
			n_s4    <= n_s3;
			cneg_s4 <= cneg_s3;

			item_s5.n    <= n_s4;
			item_s5.d    <= dabs;
			item_s5.sing <= (det_s4 == '0);
			for (int k = 0; k < m3i_pkg::N_EL; k++) begin
				item_s5.neg[k] <= cneg_s4[k] ^ det_s4[m3i_pkg::DETS_W-1];
				item_s5.ovf[k] <= m3i_pkg::CMP_W'(n_s4[k])
					>= {dabs, {m3i_pkg::HI_SH{1'b0}}};
			end
		end
	end

endmodule

// ===== rtl/core/m3i_fifo.sv =====
// ----------------------------------------------------------------------------
// m3i_fifo
// Four-entry queue between the front end and the divider array.
// ----------------------------------------------------------------------------
module m3i_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  m3i_pkg::item_t push_item,
	output logic           space,
	input  logic           pop,
	output m3i_pkg::item_t pop_item,
	output logic           avail
);

	m3i_pkg::item_t mem_q [m3i_pkg::QDEPTH];
	logic [m3i_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [m3i_pkg::QCNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign space    = (cnt_q != m3i_pkg::QCNT_W'(m3i_pkg::QDEPTH));
	assign avail    = (cnt_q != '0);
	assign do_push  = push && space;
	assign do_pop   = pop && avail;
	assign pop_item = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/core/m3i_back.sv =====
// ----------------------------------------------------------------------------
// m3i_back
// Nine-lane restoring divider, one quotient bit per stage, followed by the
// sign, saturation and singular handling in the output register.
// ----------------------------------------------------------------------------
module m3i_back (
	input  logic           clk,
	input  logic           arst_n,
	input  m3i_pkg::item_t item,
	input  logic           item_avail,
	output logic           item_pop,
	m3i_out_if.source      inv
);

	logic en;
	logic [m3i_pkg::DIV_ST:0] v_s;
	logic [m3i_pkg::DET_W-1:0] rem_s [m3i_pkg::DIV_ST+1][m3i_pkg::N_EL];
	logic [m3i_pkg::Q_W-1:0]   num_s [m3i_pkg::DIV_ST+1][m3i_pkg::N_EL];
	logic [m3i_pkg::DET_W-1:0] d_s   [m3i_pkg::DIV_ST+1];
	logic [m3i_pkg::N_EL-1:0]  neg_s [m3i_pkg::DIV_ST+1];
	logic [m3i_pkg::N_EL-1:0]  ovf_s [m3i_pkg::DIV_ST+1];
	logic                      sing_s[m3i_pkg::DIV_ST+1];

	logic [m3i_pkg::DET_W-1:0] step_rem [m3i_pkg::DIV_ST+1][m3i_pkg::N_EL];
	logic [m3i_pkg::Q_W-1:0]   step_num [m3i_pkg::DIV_ST+1][m3i_pkg::N_EL];

	logic [m3i_pkg::OUT_W-1:0] res   [m3i_pkg::N_EL];
	logic [m3i_pkg::N_EL-1:0]  lsat;

	logic                      valid_q;
	logic [m3i_pkg::OUT_W-1:0] r_q [m3i_pkg::N_EL];
	logic                      sing_q, sat_q;

	assign en       = !valid_q || inv.ready;
	assign item_pop = en && item_avail;

	always_comb begin
		logic [m3i_pkg::DET_W:0] t;
		logic ge;
		for (int k = 0; k <= m3i_pkg::DIV_ST; k++) begin
			for (int l = 0; l < m3i_pkg::N_EL; l++) begin
				step_rem[k][l] = '0;
				step_num[k][l] = '0;
			end
		end
		for (int k = 1; k <= m3i_pkg::DIV_ST; k++) begin
			for (int l = 0; l < m3i_pkg::N_EL; l++) begin
				t  = {rem_s[k-1][l], num_s[k-1][l][m3i_pkg::Q_W-1]};
				ge = (t >= {1'b0, d_s[k-1]});
				step_rem[k][l] = ge ? m3i_pkg::DET_W'(t - {1'b0, d_s[k-1]})
					: t[m3i_pkg::DET_W-1:0];
				step_num[k][l] = {num_s[k-1][l][m3i_pkg::Q_W-2:0], ge};
			end
		end
	end

	always_comb begin
		logic [m3i_pkg::Q_W-1:0] q;
		for (int l = 0; l < m3i_pkg::N_EL; l++) begin
			q = num_s[m3i_pkg::DIV_ST][l];
			if (neg_s[m3i_pkg::DIV_ST][l]) begin
				lsat[l] = ovf_s[m3i_pkg::DIV_ST][l] || (q > m3i_pkg::OUT_MIN);
				res[l]  = lsat[l] ? m3i_pkg::OUT_MIN : -q;
			end else begin
				lsat[l] = ovf_s[m3i_pkg::DIV_ST][l] || q[m3i_pkg::Q_W-1];
				res[l]  = lsat[l] ? m3i_pkg::OUT_MAX : q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s     <= '0;
			valid_q <= 1'b0;
		end else if (en) begin
			v_s     <= {v_s[m3i_pkg::DIV_ST-1:0], item_avail};
			valid_q <= v_s[m3i_pkg::DIV_ST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < m3i_pkg::N_EL; l++) begin
				rem_s[0][l] <= m3i_pkg::DET_W'(item.n[l] >> m3i_pkg::HI_SH);
				num_s[0][l] <= item.n[l] << m3i_pkg::SCALE;
			end
			d_s[0]    <= item.d;
			neg_s[0]  <= item.neg;
			ovf_s[0]  <= item.ovf;
			sing_s[0] <= item.sing;
			for (int k = 1; k <= m3i_pkg::DIV_ST; k++) begin
				for (int l = 0; l < m3i_pkg::N_EL; l++) begin
					rem_s[k][l] <= step_rem[k][l];
					num_s[k][l] <= step_num[k][l];
				end
				d_s[k]    <= d_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				sing_s[k] <= sing_s[k-1];
			end
			for (int l = 0; l < m3i_pkg::N_EL; l++) begin
				r_q[l] <= sing_s[m3i_pkg::DIV_ST] ? '0 : res[l];
			end
			sing_q <= sing_s[m3i_pkg::DIV_ST];
			sat_q  <= !sing_s[m3i_pkg::DIV_ST] && (lsat != '0);
		end
	end

	assign inv.valid     = valid_q;
	assign inv.r00       = r_q[0];
	assign inv.r01       = r_q[1];
	assign inv.r02       = r_q[2];
	assign inv.r10       = r_q[3];
	assign inv.r11       = r_q[4];
	assign inv.r12       = r_q[5];
	assign inv.r20       = r_q[6];
	assign inv.r21       = r_q[7];
	assign inv.r22       = r_q[8];
	assign inv.singular  = sing_q;
	assign inv.saturated = sat_q;

endmodule

// ===== rtl/core/matrix3_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix3_inverse
// Inverse of a signed Q8.8 3x3 matrix by the adjugate, as saturated Q16.16.
// ----------------------------------------------------------------------------
//  channel  dir  word
//  mat      in   a00..a22, signed 16 bits each
//  inv      out  r00..r22 signed 32 bits, singular, saturated
//
//  One matrix is accepted per cycle and one inverse is delivered per cycle
//  while inv is not stalled. The path runs through five front stages, one queue slot,
//  33 divider stages and the output register; the divider array retires one quotient bit per stage.
//  Reset clears all valid flags and the queue pointers; no datapath clearing.
//  A stall on inv freezes the divider array; the front end keeps accepting
//  until the four-entry queue fills.
module matrix3_inverse (
	input  logic      clk,
	input  logic      arst_n,
	m3i_in_if.sink    mat,
	m3i_out_if.source inv
);

	m3i_pkg::item_t front_item, queue_item;
	logic front_valid, queue_space, queue_avail, queue_pop;

	m3i_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mat        (mat),
		.item       (front_item),
		.item_valid (front_valid),
		.item_space (queue_space)
	);

	m3i_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_item (front_item),
		.space     (queue_space),
		.pop       (queue_pop),
		.pop_item  (queue_item),
		.avail     (queue_avail)
	);

	m3i_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (queue_item),
		.item_avail (queue_avail),
		.item_pop   (queue_pop),
		.inv        (inv)
	);

endmodule

// ===== rtl/core/m3i_checker.sv =====
// ----------------------------------------------------------------------------
// m3i_checker
// Port-level checks on the inverse words leaving the block.
// ----------------------------------------------------------------------------
module m3i_checker (
	input logic       clk,
	input logic       arst_n,
	m3i_out_if.source inv
);

	logic all_zero, any_lim;

	assign all_zero = (inv.r00 == '0) && (inv.r01 == '0) && (inv.r02 == '0)
		&& (inv.r10 == '0) && (inv.r11 == '0) && (inv.r12 == '0)
		&& (inv.r20 == '0) && (inv.r21 == '0) && (inv.r22 == '0);

	assign any_lim =
		(inv.r00 == m3i_pkg::OUT_MAX) || (inv.r00 == m3i_pkg::OUT_MIN) ||
		(inv.r01 == m3i_pkg::OUT_MAX) || (inv.r01 == m3i_pkg::OUT_MIN) ||
		(inv.r02 == m3i_pkg::OUT_MAX) || (inv.r02 == m3i_pkg::OUT_MIN) ||
		(inv.r10 == m3i_pkg::OUT_MAX) || (inv.r10 == m3i_pkg::OUT_MIN) ||
		(inv.r11 == m3i_pkg::OUT_MAX) || (inv.r11 == m3i_pkg::OUT_MIN) ||
		(inv.r12 == m3i_pkg::OUT_MAX) || (inv.r12 == m3i_pkg::OUT_MIN) ||
		(inv.r20 == m3i_pkg::OUT_MAX) || (inv.r20 == m3i_pkg::OUT_MIN) ||
		(inv.r21 == m3i_pkg::OUT_MAX) || (inv.r21 == m3i_pkg::OUT_MIN) ||
		(inv.r22 == m3i_pkg::OUT_MAX) || (inv.r22 == m3i_pkg::OUT_MIN);

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		inv.valid && inv.singular |-> all_zero && !inv.saturated)
		else $error("singular word carries nonzero data or saturation");

	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		inv.valid && inv.saturated |-> any_lim)
		else $error("saturated word has no element at a limit");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		inv.valid && !inv.ready |=> inv.valid && $stable(inv.r00)
		&& $stable(inv.r22) && $stable(inv.singular) && $stable(inv.saturated))
		else $error("stalled word changed");

endmodule

bind matrix3_inverse m3i_checker u_m3i_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.inv    (inv)
);

// ===== dv/matrix3_inverse_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix3_inverse_tb
// Streams directed and random Q8.8 matrices through the inverse block, with
// random gaps and output stalls, and compares each inverse word against a
// predictor computed in the testbench.
// ----------------------------------------------------------------------------
module matrix3_inverse_tb;

	typedef logic signed [m3i_pkg::IN_W-1:0] elem_t;
	typedef struct {
		logic [m3i_pkg::OUT_W-1:0] r [9];
		logic                      singular;
		logic                      saturated;
	} inverse_t;

	logic clk;
	logic arst_n;
	logic quiet;
	int   fail_count;
	inverse_t inverse_q [$];

	m3i_in_if  mat();
	m3i_out_if inv();

	matrix3_inverse uut (.clk(clk), .arst_n(arst_n), .mat(mat), .inv(inv));

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [m3i_pkg::OUT_W-1:0] scaled_quotient(longint cof,
		longint det, ref logic sat);
		logic [127:0] num;
		logic [127:0] den;
		logic [127:0] q;
		logic         neg;
		num = (cof < 0) ? -cof : cof;
		den = (det < 0) ? -det : det;
		neg = (cof < 0) != (det < 0);
		q = (num << m3i_pkg::SCALE) / den;
		if (!neg) begin
			if (q > 128'h7FFF_FFFF) begin
				sat = 1'b1;
				return m3i_pkg::OUT_MAX;
			end
			return q[m3i_pkg::OUT_W-1:0];
		end
		if (q > 128'h8000_0000) begin
			sat = 1'b1;
			return m3i_pkg::OUT_MIN;
		end
		return -q[m3i_pkg::OUT_W-1:0];
	endfunction

	function automatic inverse_t invert(elem_t a [9]);
		inverse_t res;
		longint   e [9];
		longint   c [9];
		longint   det;
		logic     sat;
		foreach (a[k]) e[k] = a[k];
		c[0] = e[4] * e[8] - e[5] * e[7];
		c[1] = -(e[1] * e[8] - e[2] * e[7]);
		c[2] = e[1] * e[5] - e[2] * e[4];
		c[3] = -(e[3] * e[8] - e[5] * e[6]);
		c[4] = e[0] * e[8] - e[2] * e[6];
		c[5] = -(e[0] * e[5] - e[2] * e[3]);
		c[6] = e[3] * e[7] - e[4] * e[6];
		c[7] = -(e[0] * e[7] - e[1] * e[6]);
		c[8] = e[0] * e[4] - e[1] * e[3];
		det = e[0] * c[0] + e[1] * c[3] + e[2] * c[6];
		sat = 1'b0;
		res.singular = (det == 0);
		for (int k = 0; k < 9; k++)
			res.r[k] = (det == 0) ? '0 : scaled_quotient(c[k], det, sat);
		res.saturated = sat;
		return res;
	endfunction

	task automatic report(string what, logic [m3i_pkg::OUT_W-1:0] got,
		logic [m3i_pkg::OUT_W-1:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		fail_count++;
	endtask

	task automatic send_matrix(elem_t a [9]);
		int gap;
		if (!quiet && $urandom_range(3) == 0) begin
			mat.valid <= 1'b0;
			gap = $urandom_range(1, 8);
			repeat (gap) @(posedge clk);
		end
		mat.valid <= 1'b1;
		{mat.a00, mat.a01, mat.a02, mat.a10, mat.a11, mat.a12, mat.a20, mat.a21,
			mat.a22} <= {a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7], a[8]};
		do @(posedge clk); while (!mat.ready);
		inverse_q.push_back(invert(a));
	endtask

	task automatic idle_input();
		mat.valid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		inverse_t want;
		logic [m3i_pkg::OUT_W-1:0] got [9];
		if (arst_n && inv.valid && inv.ready) begin
			got = '{inv.r00, inv.r01, inv.r02, inv.r10, inv.r11, inv.r12, inv.r20,
				inv.r21, inv.r22};
			if (inverse_q.size() == 0) begin
				report("unexpected word", 0, 0);
			end else begin
				want = inverse_q.pop_front();
				for (int k = 0; k < 9; k++)
					if (got[k] !== want.r[k])
						report($sformatf("r%0d%0d", k / 3, k % 3), got[k], want.r[k]);
				if (inv.singular !== want.singular)
					report("singular", inv.singular, want.singular);
				if (inv.saturated !== want.saturated)
					report("saturated", inv.saturated, want.saturated);
			end
		end
	end

	int stall_left;
	always @(posedge clk) begin
		if (quiet || !arst_n) begin
			inv.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			inv.ready <= 1'b0;
		end else if ($urandom_range(4) == 0) begin
			stall_left <= $urandom_range(0, 7);
			inv.ready <= 1'b0;
		end else begin
			inv.ready <= 1'b1;
		end
	end

	task automatic wait_drained();
		int guard;
		guard = 0;
		while (inverse_q.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		if (guard >= 100000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	endtask

	function automatic elem_t rand_elem();
		case ($urandom_range(5))
			0: return elem_t'(16'h8000);
			1: return elem_t'(16'h7FFF);
			2: return elem_t'($urandom_range(0, 1023) - 512);
			3: return elem_t'($urandom_range(0, 15) - 8);
			default: return elem_t'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		elem_t m [9];
		m = '{256, 0, 0, 0, 256, 0, 0, 0, 256};
		send_matrix(m);
		m = '{-256, 0, 0, 0, 512, 0, 0, 0, 128};
		send_matrix(m);
		m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
		send_matrix(m);
		m = '{-1, 0, 0, 0, -1, 0, 0, 0, 1};
		send_matrix(m);
		m = '{1, 2, 3, 4, 5, 6, 7, 8, 9};
		send_matrix(m);
		m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_matrix(m);
		m = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
		send_matrix(m);
		m = '{32767, 0, 0, 0, 32767, 0, 0, 0, 32767};
		send_matrix(m);
		m = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};
		send_matrix(m);
		m = '{-32768, 32767, 0, 32767, -32768, 32767, 0, 32767, -32768};
		send_matrix(m);
		m = '{32767, -32768, 32767, -32768, 32767, 0, 32767, 0, -32768};
		send_matrix(m);
		m = '{3, 1, 0, 0, 3, 1, 1, 0, 3};
		send_matrix(m);
		m = '{-3, 1, 0, 0, 3, -1, 1, 0, 7};
		send_matrix(m);
		m = '{0, 256, 0, 256, 0, 0, 0, 0, 256};
		send_matrix(m);
		idle_input();
	endtask

	task automatic test_random(int count);
		elem_t m [9];
		for (int n = 0; n < count; n++) begin
			foreach (m[k]) m[k] = rand_elem();
			if ($urandom_range(9) == 0)
				for (int k = 0; k < 3; k++) m[6 + k] = m[3 + k];
			send_matrix(m);
		end
		idle_input();
	endtask

	initial begin
		fail_count = 0;
		quiet = 1'b0;
		stall_left = 0;
		arst_n = 1'b0;
		mat.valid = 1'b0;
		{mat.a00, mat.a01, mat.a02, mat.a10, mat.a11, mat.a12, mat.a20, mat.a21,
			mat.a22} = '0;
		inv.ready = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_drained();
		test_random(500);
		wait_drained();
		test_random(250);
		quiet = 1'b1;
		test_random(200);
		wait_drained();
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
